>>> design/wip_pkg.sv
// ----------------------------------------------------------------------------
// wip_pkg
// Shared types, constants and helper functions of the wake interval planner.
// ----------------------------------------------------------------------------
package wip_pkg;

  localparam int TIME_BITS = 40;

  localparam int MIN_W    = 11;
  localparam int OFS_W    = 17;
  localparam int SEC_W    = 17;
  localparam int IVL_W    = 17;
  localparam int CD_W     = 18;
  localparam int SUM3_W   = 19;
  localparam int STREAK_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_BATT,
    REG_CHECK_USB,
    REG_QUIET_START,
    REG_QUIET_END,
    REG_UTC_OFS
  } cfg_reg_t;

  localparam int DAY_SECS       = 86400;
  localparam int MIN_SLEEP      = 60;
  localparam int LONG_BACKOFF   = 3 * 3600;
  localparam int BACKOFF_STREAK = 24;
  localparam int RETRY_STEPS    = 3;
  localparam int RESET_MIN_BATT = 60;
  localparam int RESET_MIN_USB  = 15;

  localparam logic [IVL_W-1:0] RETRY_SECS [RETRY_STEPS] = '{
    IVL_W'(5 * 60), IVL_W'(15 * 60), IVL_W'(30 * 60)
  };

  // Day-of-second unit: 86400 = 128 * 675, so the low seven bits pass
  // through and the rest is reduced modulo 675 by folding and a reciprocal.
  localparam int DM_LO_W   = 7;
  localparam int DM_DIV    = 675;
  localparam int DM_X_W    = TIME_BITS - DM_LO_W;
  localparam int DM_CH_W   = 12;
  localparam int DM_NCH    = (DM_X_W + DM_CH_W - 1) / DM_CH_W;
  localparam int DM_WT_W   = 10;
  localparam int DM_PROD_W = DM_CH_W + DM_WT_W;
  localparam int DM_SUM_W  = DM_PROD_W + $clog2(DM_NCH);
  localparam int DM_RS     = DM_SUM_W + DM_WT_W;
  localparam int DM_M_W    = DM_SUM_W + 1;
  localparam int DM_Q_W    = DM_SUM_W - 9;
  localparam logic [DM_M_W-1:0] DM_RECIP =
    DM_M_W'(((64'd1 << DM_RS) + DM_DIV - 1) / DM_DIV);
  localparam int DM_STAGES = 4;

  // Pipeline stage numbers of the top level.
  localparam int ST_SUM3  = DM_STAGES;
  localparam int ST_SOD   = DM_STAGES + 1;
  localparam int ST_QUIET = DM_STAGES + 2;
  localparam int ST_CD    = DM_STAGES + 3;
  localparam int ST_OUT   = DM_STAGES + 4;
  localparam int NST      = DM_STAGES + 5;

  typedef struct packed {
    logic             tvalid;
    logic [IVL_W-1:0] ivl;
    logic             show_near;
    logic [CD_W-1:0]  show_dt;
  } side_t;

  function automatic logic [IVL_W-1:0] min_to_sec(input logic [MIN_W-1:0] mins);
    return (IVL_W'(mins) << 6) - (IVL_W'(mins) << 2);
  endfunction

  // Weight of a 12-bit chunk: 2^(12*idx) mod 675.
  function automatic logic [DM_WT_W-1:0] dm_weight(input int idx);
    longint unsigned w;
    w = 1;
    for (int k = 0; k < idx; k++) begin
      w = (w << DM_CH_W) % DM_DIV;
    end
    return DM_WT_W'(w);
  endfunction

endpackage

>>> design/wip_in_if.sv
// ----------------------------------------------------------------------------
// wip_in_if
// Request channel of the wake interval planner.
// ----------------------------------------------------------------------------
interface wip_in_if;
  import wip_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TIME_BITS-1:0]     now_seconds;
  logic                     on_usb;
  logic [STREAK_W-1:0]      fail_streak;
  logic                     time_valid;
  logic [TIME_BITS-1:0]     next_show_time;

  modport source (output valid, now_seconds, on_usb, fail_streak, time_valid,
                  next_show_time, input ready);
  modport sink (input valid, now_seconds, on_usb, fail_streak, time_valid,
                next_show_time, output ready);
endinterface

>>> design/wip_out_if.sv
// ----------------------------------------------------------------------------
// wip_out_if
// Result channel of the wake interval planner.
// ----------------------------------------------------------------------------
interface wip_out_if;
  import wip_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] sleep_seconds;
  logic             is_check;

  modport source (output valid, sleep_seconds, is_check, input ready);
  modport sink (input valid, sleep_seconds, is_check, output ready);
endinterface

>>> design/wip_cfg_if.sv
// ----------------------------------------------------------------------------
// wip_cfg_if
// Register write channel of the wake interval planner.
// ----------------------------------------------------------------------------
interface wip_cfg_if;
  import wip_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

>>> design/wip_daymod.sv
// ----------------------------------------------------------------------------
// wip_daymod
// Four-stage pipeline giving the second of the UTC day of an epoch time.
// ----------------------------------------------------------------------------
module wip_daymod (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [wip_pkg::TIME_BITS-1:0] now_seconds,
  output logic [wip_pkg::SEC_W-1:0]     now_sod
);
  import wip_pkg::*;

  logic [DM_CH_W*DM_NCH-1:0]   x_pad;
  logic [DM_PROD_W-1:0]        prod_nxt [DM_NCH];
  logic [DM_PROD_W-1:0]        prod_r [DM_NCH];
  logic [DM_LO_W-1:0]          lo_r [DM_STAGES-1];
  logic [DM_SUM_W-1:0]         sum_nxt;
  logic [DM_SUM_W-1:0]         sum_r;
  logic [DM_SUM_W+DM_M_W-1:0]  recip_prod;
  logic [DM_Q_W-1:0]           q_r;
  logic [DM_WT_W-1:0]          vlo_r;
  logic [DM_WT_W-1:0]          rem_nxt;
  logic [SEC_W-1:0]            sod_r;

  assign x_pad = (DM_CH_W*DM_NCH)'(now_seconds[TIME_BITS-1:DM_LO_W]);

  // Each chunk is replaced by its residue weight times its value; the sum
  // is congruent to the upper time bits modulo 675.
  for (genvar i = 0; i < DM_NCH; i++) begin : g_fold
    localparam logic [DM_WT_W-1:0] WT = dm_weight(i);
    assign prod_nxt[i] = DM_PROD_W'(x_pad[i*DM_CH_W +: DM_CH_W]) * DM_PROD_W'(WT);
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < DM_NCH; i++) begin
      sum_nxt = sum_nxt + DM_SUM_W'(prod_r[i]);
    end
  end

  // The reciprocal is rounded up with enough fraction bits that the
  // quotient is exact over the whole range of the folded sum.
  assign recip_prod = (DM_SUM_W+DM_M_W)'(sum_r) * (DM_SUM_W+DM_M_W)'(DM_RECIP);

  // The remainder is below 1024, so ten bits of the difference suffice.
  assign rem_nxt = vlo_r - DM_WT_W'(q_r[DM_WT_W-1:0] * DM_WT_W'(DM_DIV));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DM_NCH; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      lo_r[0] <= now_seconds[DM_LO_W-1:0];
      for (int k = 1; k < DM_STAGES - 1; k++) begin
        lo_r[k] <= lo_r[k-1];
      end
      sum_r <= sum_nxt;
      q_r   <= recip_prod[DM_RS +: DM_Q_W];
      vlo_r <= sum_r[DM_WT_W-1:0];
      sod_r <= {rem_nxt, lo_r[DM_STAGES-2]};
    end
  end

  assign now_sod = sod_r;

endmodule

>>> design/wake_interval_planner.sv
// ----------------------------------------------------------------------------
// wake_interval_planner
// Plans the next sleep length and wake kind from time, power and failures.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_ch    in   now_seconds, on_usb, fail_streak, time_valid, next_show_time
//  out_ch   out  sleep_seconds, is_check
//  cfg_ch   in   index, wdata (register write, always ready)
//
//  Nine register stages; one request is taken per cycle while the output
//  register is empty or taken.
//  The day-of-second reduction of the 40-bit time fills the first four stages.
//  Reset is synchronous and active low; it empties the pipeline and loads the
//  register defaults.
//  All stages advance together whenever the output register is empty or taken.
// ----------------------------------------------------------------------------
module wake_interval_planner (
  input  logic  clk,
  input  logic  rst_n,
  wip_in_if.sink    in_ch,
  wip_out_if.source out_ch,
  wip_cfg_if.sink   cfg_ch
);
  import wip_pkg::*;

  logic [IVL_W-1:0]        chk_batt_r;
  logic [IVL_W-1:0]        chk_usb_r;
  logic [IVL_W-1:0]        quiet_start_r;
  logic [IVL_W-1:0]        quiet_end_r;
  logic signed [OFS_W-1:0] utc_ofs_r;

  logic [NST-1:0]          v_r;
  logic                    adv;
  side_t                   side_nxt;
  side_t                   side_r [NST-1];

  logic [IVL_W-1:0]        ivl_nxt;
  logic [IVL_W-1:0]        base_sec;
  logic [IVL_W-1:0]        retry_sec;
  logic [TIME_BITS-1:0]    show_diff;
  logic [OFS_W:0]          ofs_wrap;
  logic [SEC_W-1:0]        ofs_day;
  logic [SEC_W-1:0]        dm_sod;

  logic [SUM3_W-1:0]       t_nxt;
  logic [SUM3_W-1:0]       t_r;
  logic [SEC_W-1:0]        sod_nxt;
  logic [SEC_W-1:0]        sod_r;
  logic                    quiet_nxt;
  logic                    quiet_r;
  logic [SEC_W:0]          add_raw;
  logic [SEC_W-1:0]        add_nxt;
  logic [SEC_W-1:0]        add_r;
  logic [CD_W-1:0]         cd_nxt;
  logic [CD_W-1:0]         cd_r;
  logic [CD_W-1:0]         wake_sec;
  logic                    is_check_nxt;
  logic                    is_check_r;
  logic [SEC_W-1:0]        sleep_nxt;
  logic [SEC_W-1:0]        sleep_r;

  // Register file; minute settings are kept as seconds.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_batt_r    <= min_to_sec(MIN_W'(RESET_MIN_BATT));
      chk_usb_r     <= min_to_sec(MIN_W'(RESET_MIN_USB));
      quiet_start_r <= '0;
      quiet_end_r   <= '0;
      utc_ofs_r     <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CHECK_BATT:  chk_batt_r    <= min_to_sec(cfg_ch.wdata[MIN_W-1:0]);
        REG_CHECK_USB:   chk_usb_r     <= min_to_sec(cfg_ch.wdata[MIN_W-1:0]);
        REG_QUIET_START: quiet_start_r <= min_to_sec(cfg_ch.wdata[MIN_W-1:0]);
        REG_QUIET_END:   quiet_end_r   <= min_to_sec(cfg_ch.wdata[MIN_W-1:0]);
        REG_UTC_OFS:     utc_ofs_r     <= cfg_ch.wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // The offset lies within one day either side, so one add folds it in.
  assign ofs_wrap = {utc_ofs_r[OFS_W-1], utc_ofs_r} + (OFS_W+1)'(DAY_SECS);
  assign ofs_day  = utc_ofs_r[OFS_W-1] ? ofs_wrap[SEC_W-1:0] : SEC_W'(utc_ofs_r);

  // Pipeline control: every stage moves when the output slot frees up.
  assign adv          = !v_r[ST_OUT] || out_ch.ready;
  assign in_ch.ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_ch.valid};
    end
  end

  // Stage 0: check interval and the distance to the pending message.
  assign base_sec  = in_ch.on_usb ? chk_usb_r : chk_batt_r;
  assign retry_sec = RETRY_SECS[in_ch.fail_streak[1:0] - 2'd1];
  assign show_diff = in_ch.next_show_time - in_ch.now_seconds;

  always_comb begin
    ivl_nxt = base_sec;
    if (in_ch.fail_streak != '0 && in_ch.fail_streak <= STREAK_W'(RETRY_STEPS)) begin
      if (retry_sec < base_sec) begin
        ivl_nxt = retry_sec;
      end
    end else if (in_ch.fail_streak > STREAK_W'(BACKOFF_STREAK) && !in_ch.on_usb &&
                 base_sec < IVL_W'(LONG_BACKOFF)) begin
      ivl_nxt = IVL_W'(LONG_BACKOFF);
    end
    side_nxt.tvalid    = in_ch.time_valid;
    side_nxt.ivl       = ivl_nxt;
    side_nxt.show_near = (in_ch.next_show_time > in_ch.now_seconds) &&
                         (show_diff[TIME_BITS-1:CD_W] == '0);
    side_nxt.show_dt   = show_diff[CD_W-1:0];
  end

  wip_daymod u_daymod (
    .clk         (clk),
    .adv         (adv),
    .now_seconds (in_ch.now_seconds),
    .now_sod     (dm_sod)
  );

  // Local second of day of the check time, before reduction.
  assign t_nxt = SUM3_W'(dm_sod) + SUM3_W'(side_r[ST_SUM3-1].ivl) + SUM3_W'(ofs_day);

  // The sum stays below four days.
  always_comb begin
    if (t_r >= SUM3_W'(3 * DAY_SECS)) begin
      sod_nxt = SEC_W'(t_r - SUM3_W'(3 * DAY_SECS));
    end else if (t_r >= SUM3_W'(2 * DAY_SECS)) begin
      sod_nxt = SEC_W'(t_r - SUM3_W'(2 * DAY_SECS));
    end else if (t_r >= SUM3_W'(DAY_SECS)) begin
      sod_nxt = SEC_W'(t_r - SUM3_W'(DAY_SECS));
    end else begin
      sod_nxt = SEC_W'(t_r);
    end
  end

  // Quiet window test in seconds; the minute bounds compare the same way.
  always_comb begin
    if (quiet_start_r == quiet_end_r) begin
      quiet_nxt = 1'b0;
    end else if (quiet_start_r < quiet_end_r) begin
      quiet_nxt = (sod_r >= quiet_start_r) && (sod_r < quiet_end_r);
    end else begin
      quiet_nxt = (sod_r >= quiet_start_r) || (sod_r < quiet_end_r);
    end
    add_raw = {1'b0, quiet_end_r} - {1'b0, sod_r};
    if (add_raw[SEC_W] || add_raw == '0) begin
      add_nxt = SEC_W'(add_raw + (SEC_W+1)'(DAY_SECS));
    end else begin
      add_nxt = add_raw[SEC_W-1:0];
    end
  end

  assign cd_nxt = CD_W'(side_r[ST_CD-1].ivl) + (quiet_r ? CD_W'(add_r) : '0);

  // Final choice between check and message, then the sleep clamp.
  always_comb begin
    if (!side_r[ST_OUT-1].tvalid) begin
      wake_sec     = CD_W'(side_r[ST_OUT-1].ivl);
      is_check_nxt = 1'b1;
    end else if (side_r[ST_OUT-1].show_near && side_r[ST_OUT-1].show_dt < cd_r) begin
      wake_sec     = side_r[ST_OUT-1].show_dt;
      is_check_nxt = 1'b0;
    end else begin
      wake_sec     = cd_r;
      is_check_nxt = 1'b1;
    end
    if (wake_sec < CD_W'(MIN_SLEEP)) begin
      sleep_nxt = SEC_W'(MIN_SLEEP);
    end else if (wake_sec > CD_W'(DAY_SECS)) begin
      sleep_nxt = SEC_W'(DAY_SECS);
    end else begin
      sleep_nxt = SEC_W'(wake_sec);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < NST - 1; k++) begin
        side_r[k] <= side_r[k-1];
      end
      t_r        <= t_nxt;
      sod_r      <= sod_nxt;
      quiet_r    <= quiet_nxt;
      add_r      <= add_nxt;
      cd_r       <= cd_nxt;
      sleep_r    <= sleep_nxt;
      is_check_r <= is_check_nxt;
    end
  end

  assign out_ch.valid         = v_r[ST_OUT];
  assign out_ch.sleep_seconds = sleep_r;
  assign out_ch.is_check      = is_check_r;

  a_daymod_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DM_STAGES-1] |-> dm_sod < SEC_W'(DAY_SECS))
    else $error("day-of-second unit gave a value of a day or more");

  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_SOD] |-> sod_r < SEC_W'(DAY_SECS))
    else $error("local second of day out of range");

  a_quiet_shift: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_QUIET] && quiet_r |-> add_r != '0)
    else $error("quiet window shift is zero");

  a_sleep_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_OUT] |-> sleep_r >= SEC_W'(MIN_SLEEP) && sleep_r <= SEC_W'(DAY_SECS))
    else $error("sleep length outside its clamp");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[ST_OUT-1] |=> v_r[ST_OUT])
    else $error("result lost between last stage and output register");

endmodule

>>> tb/wake_interval_planner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wake_interval_planner_tb
// Checks the wake interval planner against a cycle-free model of its sleep
// plan. Requests go in bursts with random gaps, the result side stalls on a
// pattern of its own, and the register settings change between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module wake_interval_planner_tb;
  import wip_pkg::*;

  localparam int CLK_HALF_NS  = 10;
  localparam int DRAIN_CYCLES = 24;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int PHASE_ITEMS  = 195;

  typedef struct {
    logic [TIME_BITS-1:0] now_seconds;
    logic                 on_usb;
    logic [STREAK_W-1:0]  fail_streak;
    logic                 time_valid;
    logic [TIME_BITS-1:0] next_show_time;
  } wake_req_t;

  typedef struct {
    logic [SEC_W-1:0] sleep_seconds;
    logic             is_check;
  } wake_plan_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_t;

  logic clk;
  logic rst_n;

  wip_in_if  in_ch ();
  wip_out_if out_ch ();
  wip_cfg_if cfg_ch ();

  wake_interval_planner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register copies as seen through the write channel.
  logic [MIN_W-1:0] batt_minutes;
  logic [MIN_W-1:0] usb_minutes;
  logic [MIN_W-1:0] quiet_start;
  logic [MIN_W-1:0] quiet_end;
  int               utc_offset;

  wake_req_t  queued_requests[$];
  wake_plan_t planned_wakes[$];
  int         requests_issued;
  int         requests_taken;
  int         mismatches;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic wake_plan_t plan_wake(wake_req_t q);
    longint     now_t;
    longint     show_t;
    longint     ivl;
    longint     ofs;
    longint     sod;
    longint     check_dt;
    longint     shift;
    longint     wake_dt;
    longint     mins;
    logic       quiet;
    wake_plan_t p;
    now_t  = longint'(q.now_seconds);
    show_t = longint'(q.next_show_time);
    ivl    = longint'(q.on_usb ? usb_minutes : batt_minutes) * 60;
    if (q.fail_streak == 1 && ivl > 300) begin
      ivl = 300;
    end else if (q.fail_streak == 2 && ivl > 900) begin
      ivl = 900;
    end else if (q.fail_streak == 3 && ivl > 1800) begin
      ivl = 1800;
    end else if (q.fail_streak > 24 && !q.on_usb && ivl < 10800) begin
      ivl = 10800;
    end
    p.is_check = 1'b1;
    wake_dt    = ivl;
    if (q.time_valid) begin
      ofs = longint'(utc_offset) % 86400;
      if (ofs < 0) begin
        ofs += 86400;
      end
      sod  = ((now_t % 86400) + ivl + ofs) % 86400;
      mins = sod / 60;
      if (quiet_start == quiet_end) begin
        quiet = 1'b0;
      end else if (quiet_start < quiet_end) begin
        quiet = (mins >= quiet_start) && (mins < quiet_end);
      end else begin
        quiet = (mins >= quiet_start) || (mins < quiet_end);
      end
      check_dt = ivl;
      if (quiet) begin
        // The check slides to the next local time the window closes.
        shift = longint'(quiet_end) * 60 - sod;
        if (shift <= 0) begin
          shift += 86400;
        end
        check_dt += shift;
      end
      wake_dt = check_dt;
      if (show_t > now_t && (show_t - now_t) < check_dt) begin
        wake_dt    = show_t - now_t;
        p.is_check = 1'b0;
      end
    end
    if (wake_dt < 60) begin
      wake_dt = 60;
    end
    if (wake_dt > 86400) begin
      wake_dt = 86400;
    end
    p.sleep_seconds = SEC_W'(wake_dt);
    return p;
  endfunction

  function automatic wake_req_t make_req(logic [TIME_BITS-1:0] now_s, logic usb,
                                         logic [STREAK_W-1:0] streak, logic tv,
                                         logic [TIME_BITS-1:0] show);
    wake_req_t q;
    q.now_seconds    = now_s;
    q.on_usb         = usb;
    q.fail_streak    = streak;
    q.time_valid     = tv;
    q.next_show_time = show;
    return q;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic wake_req_t rand_req();
    wake_req_t q;
    case ($urandom_range(0, 9))
      0:       q.now_seconds = rand_time();
      1:       q.now_seconds = TIME_BITS'($urandom_range(0, 200000));
      2:       q.now_seconds = '1 - TIME_BITS'($urandom_range(0, 200000));
      default: q.now_seconds = TIME_BITS'(64'd1700000000 + $urandom);
    endcase
    q.on_usb = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: q.fail_streak = STREAK_W'($urandom_range(0, 5));
      6, 7:             q.fail_streak = STREAK_W'($urandom_range(20, 30));
      8:                q.fail_streak = STREAK_W'($urandom);
      default:          q.fail_streak = '1 - STREAK_W'($urandom_range(0, 1));
    endcase
    q.time_valid = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7:
        q.next_show_time = q.now_seconds + TIME_BITS'($urandom_range(0, 2 * 86400));
      8, 9, 10:
        q.next_show_time = q.now_seconds - TIME_BITS'($urandom_range(0, 5000));
      11, 12:  q.next_show_time = q.now_seconds;
      13, 14, 15: q.next_show_time = rand_time();
      default: q.next_show_time = '0;
    endcase
    return q;
  endfunction

  task automatic queue_req(wake_req_t q);
    queued_requests.push_back(q);
    requests_issued++;
  endtask

  task automatic wait_idle();
    while (requests_taken != requests_issued || planned_wakes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(int batt, int usb, int qs, int qe, int ofs);
    write_reg(REG_CHECK_BATT, CFG_DATA_W'(batt));
    write_reg(REG_CHECK_USB, CFG_DATA_W'(usb));
    write_reg(REG_QUIET_START, CFG_DATA_W'(qs));
    write_reg(REG_QUIET_END, CFG_DATA_W'(qe));
    write_reg(REG_UTC_OFS, CFG_DATA_W'(ofs));
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      queue_req(rand_req());
    end
  endtask

  // Register copy follows every accepted write beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      batt_minutes = MIN_W'(RESET_MIN_BATT);
      usb_minutes  = MIN_W'(RESET_MIN_USB);
      quiet_start  = '0;
      quiet_end    = '0;
      utc_offset   = 0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CHECK_BATT:  batt_minutes = cfg_ch.wdata[MIN_W-1:0];
        REG_CHECK_USB:   usb_minutes  = cfg_ch.wdata[MIN_W-1:0];
        REG_QUIET_START: quiet_start  = cfg_ch.wdata[MIN_W-1:0];
        REG_QUIET_END:   quiet_end    = cfg_ch.wdata[MIN_W-1:0];
        REG_UTC_OFS:     utc_offset   = int'($signed(cfg_ch.wdata[OFS_W-1:0]));
        default: ;
      endcase
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  int        burst_left;
  int        gap_left;
  wake_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        planned_wakes.push_back(plan_wake(make_req(in_ch.now_seconds, in_ch.on_usb,
                                                   in_ch.fail_streak, in_ch.time_valid,
                                                   in_ch.next_show_time)));
        requests_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          next_req = queued_requests.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.now_seconds    <= next_req.now_seconds;
          in_ch.on_usb         <= next_req.on_usb;
          in_ch.fail_streak    <= next_req.fail_streak;
          in_ch.time_valid     <= next_req.time_valid;
          in_ch.next_show_time <= next_req.next_show_time;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  rx_mode_t   rx_mode;
  int         rx_mode_left;
  int         rx_run_left;
  logic       rx_run_ready;
  wake_plan_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (planned_wakes.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result beat: sleep=%0d check=%0b",
                   out_ch.sleep_seconds, out_ch.is_check);
        end
        mismatches++;
      end else begin
        want = planned_wakes.pop_front();
        if (out_ch.sleep_seconds !== want.sleep_seconds ||
            out_ch.is_check !== want.is_check) begin
          if (mismatches < 10) begin
            $display("Result mismatch: sleep exp %0d got %0d, check exp %0b got %0b",
                     want.sleep_seconds, out_ch.sleep_seconds,
                     want.is_check, out_ch.is_check);
          end
          mismatches++;
        end
      end
    end
    if (rx_mode_left <= 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN: out_ch.ready <= 1'b1;
      RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_run_left <= 0) begin
          rx_run_ready = !rx_run_ready;
          rx_run_left  = rx_run_ready ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        rx_run_left--;
        out_ch.ready <= rx_run_ready;
      end
    endcase
  end

  logic [TIME_BITS-1:0] t0;

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.now_seconds    = '0;
    in_ch.on_usb         = 1'b0;
    in_ch.fail_streak    = '0;
    in_ch.time_valid     = 1'b0;
    in_ch.next_show_time = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.wdata         = '0;
    requests_issued      = 0;
    requests_taken       = 0;
    mismatches           = 0;
    rx_mode              = RX_OPEN;
    rx_mode_left         = 0;
    rx_run_left          = 0;
    rx_run_ready         = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: edge times, retry and backoff streaks, message timing.
    t0 = TIME_BITS'(64'd1700000000);
    queue_req(make_req('0, 1'b0, 16'd0, 1'b1, '0));
    queue_req(make_req('1, 1'b1, 16'd0, 1'b1, '1));
    queue_req(make_req('1, 1'b0, 16'hFFFF, 1'b1, '0));
    queue_req(make_req(t0, 1'b0, 16'd1, 1'b0, '0));
    queue_req(make_req(t0, 1'b1, 16'd2, 1'b1, '0));
    queue_req(make_req(t0, 1'b0, 16'd3, 1'b1, '0));
    queue_req(make_req(t0, 1'b0, 16'd4, 1'b1, '0));
    queue_req(make_req(t0, 1'b0, 16'd24, 1'b1, '0));
    queue_req(make_req(t0, 1'b0, 16'd25, 1'b1, '0));
    queue_req(make_req(t0, 1'b1, 16'd25, 1'b1, '0));
    queue_req(make_req(t0, 1'b0, 16'hFFFF, 1'b0, '0));
    queue_req(make_req(t0, 1'b0, 16'd0, 1'b1, t0 + 1));
    queue_req(make_req(t0, 1'b0, 16'd0, 1'b1, t0 + 59));
    queue_req(make_req(t0, 1'b0, 16'd0, 1'b1, t0 + 3599));
    queue_req(make_req(t0, 1'b0, 16'd0, 1'b1, t0 + 3600));
    queue_req(make_req(t0, 1'b0, 16'd0, 1'b1, t0 - 1));
    queue_req(make_req(t0, 1'b0, 16'd0, 1'b1, t0));
    queue_req(make_req(t0, 1'b1, 16'd1, 1'b0, t0 + 10));
    queue_req(make_req('1 - 100, 1'b0, 16'd0, 1'b1, '1));
    queue_req(make_req(40'hAA_AAAA_AAAA, 1'b1, 16'hAAAA, 1'b1, 40'h55_5555_5555));
    queue_random(PHASE_ITEMS);
    wait_idle();

    // Zero intervals fall to the minimum sleep.
    apply_setting(0, 0, 0, 0, 0);
    queue_random(PHASE_ITEMS);
    wait_idle();

    // Largest in-range intervals, a window wrapping midnight, largest offset.
    apply_setting(1440, 1440, 1439, 0, 50400);
    queue_random(PHASE_ITEMS);
    wait_idle();

    // Overnight quiet window with the most negative in-range offset.
    apply_setting(60, 15, 1320, 420, -43200);
    queue_random(PHASE_ITEMS);
    wait_idle();

    // Daytime window that does not wrap.
    apply_setting(30, 5, 60, 600, 3600);
    queue_random(PHASE_ITEMS);
    wait_idle();

    // Out-of-range values: an end minute past the day, most negative offset.
    apply_setting(2047, 2047, 100, 2047, -65536);
    queue_random(PHASE_ITEMS);
    wait_idle();

    apply_setting(200, 1, 2000, 5, 65535);
    queue_random(PHASE_ITEMS);
    wait_idle();

    for (int s = 0; s < 2; s++) begin
      apply_setting($urandom_range(0, 1440), $urandom_range(0, 1440),
                    $urandom_range(0, 1439), $urandom_range(0, 1439),
                    int'($urandom_range(0, 93600)) - 43200);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && planned_wakes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
